// ===== rtl/sic_pkg.sv =====
// Shared types and constants for the segment intersection classifier.
`default_nettype none

package sic_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int CROSS_TOL_W     = 32;
  localparam int COORD_TOL_W     = 8;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_INDEX_W     = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_CROSS_TOL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COORD_TOL = 2'd1;

  typedef enum logic [1:0] {
    CONTACT_NONE  = 2'd0,
    CONTACT_POINT = 2'd1,
    CONTACT_LINE  = 2'd2
  } contact_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } sign_t;

endpackage

`default_nettype wire

// ===== rtl/sic_cross.sv =====
// Edge vectors and the two partial products of one orientation cross product.
`default_nettype none

module sic_cross #(
  parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
  input  wire logic signed [COORD_WIDTH-1:0]   p_x,
  input  wire logic signed [COORD_WIDTH-1:0]   p_y,
  input  wire logic signed [COORD_WIDTH-1:0]   q_x,
  input  wire logic signed [COORD_WIDTH-1:0]   q_y,
  input  wire logic signed [COORD_WIDTH-1:0]   r_x,
  input  wire logic signed [COORD_WIDTH-1:0]   r_y,
  output logic signed [2*COORD_WIDTH+1:0]      prod_uv,
  output logic signed [2*COORD_WIDTH+1:0]      prod_vu
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 2;

  logic signed [DW-1:0] ux;
  logic signed [DW-1:0] uy;
  logic signed [DW-1:0] vx;
  logic signed [DW-1:0] vy;

  assign ux = DW'(q_x) - DW'(p_x);
  assign uy = DW'(q_y) - DW'(p_y);
  assign vx = DW'(r_x) - DW'(p_x);
  assign vy = DW'(r_y) - DW'(p_y);

  assign prod_uv = PW'(ux) * PW'(vy);
  assign prod_vu = PW'(vx) * PW'(uy);

endmodule

`default_nettype wire

// ===== rtl/sic_sign.sv =====
// Orientation sign of one cross product against the cross tolerance.
`default_nettype none

module sic_sign #(
  parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
  input  wire logic signed [2*COORD_WIDTH+1:0]   prod_uv,
  input  wire logic signed [2*COORD_WIDTH+1:0]   prod_vu,
  input  wire logic [sic_pkg::CROSS_TOL_W-1:0]   cross_tol,
  output sic_pkg::sign_t                         sign
);

  import sic_pkg::*;

  localparam int CW   = 2 * COORD_WIDTH + 3;
  localparam int CMPW = (CW > CROSS_TOL_W + 1) ? CW : CROSS_TOL_W + 1;

  logic signed [CW-1:0] cross_sum;
  logic [CW-1:0]        mag;
  logic [CMPW-1:0]      mag_ext;
  logic [CMPW-1:0]      tol_ext;

  assign cross_sum = CW'(prod_uv) - CW'(prod_vu);
  assign mag       = cross_sum[CW-1] ? CW'(-cross_sum) : CW'(cross_sum);
  assign mag_ext   = CMPW'(mag);
  assign tol_ext   = CMPW'(cross_tol);

  assign sign.zero = (mag_ext <= tol_ext);
  assign sign.neg  = cross_sum[CW-1];

endmodule

`default_nettype wire

// ===== rtl/sic_collinear.sv =====
// Axis choice, endpoint ordering and touch/overlap tests for collinear segments.
`default_nettype none

module sic_collinear #(
  parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
  input  wire logic signed [COORD_WIDTH-1:0]     a_start_x,
  input  wire logic signed [COORD_WIDTH-1:0]     a_start_y,
  input  wire logic signed [COORD_WIDTH-1:0]     a_end_x,
  input  wire logic signed [COORD_WIDTH-1:0]     a_end_y,
  input  wire logic signed [COORD_WIDTH-1:0]     b_start_x,
  input  wire logic signed [COORD_WIDTH-1:0]     b_start_y,
  input  wire logic signed [COORD_WIDTH-1:0]     b_end_x,
  input  wire logic signed [COORD_WIDTH-1:0]     b_end_y,
  input  wire logic [sic_pkg::COORD_TOL_W-1:0]   coord_tol,
  output logic                                   touch,
  output logic                                   overlap
);

  import sic_pkg::*;

  localparam int DW = COORD_WIDTH + 1;

  function automatic logic near_eq(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b,
    input logic [COORD_TOL_W-1:0]        tol
  );
    logic signed [DW-1:0] diff;
    logic [DW-1:0]        mag;
    diff = DW'(a) - DW'(b);
    mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
    return mag <= DW'(tol);
  endfunction

  logic                          use_y;
  logic signed [COORD_WIDTH-1:0] a_first;
  logic signed [COORD_WIDTH-1:0] a_second;
  logic signed [COORD_WIDTH-1:0] b_first;
  logic signed [COORD_WIDTH-1:0] b_second;
  logic signed [COORD_WIDTH-1:0] alo;
  logic signed [COORD_WIDTH-1:0] ahi;
  logic signed [COORD_WIDTH-1:0] blo;
  logic signed [COORD_WIDTH-1:0] bhi;

  assign use_y = near_eq(a_start_x, a_end_x, coord_tol) &&
                 near_eq(b_start_x, b_end_x, coord_tol);

  assign a_first  = use_y ? a_start_y : a_start_x;
  assign a_second = use_y ? a_end_y   : a_end_x;
  assign b_first  = use_y ? b_start_y : b_start_x;
  assign b_second = use_y ? b_end_y   : b_end_x;

  assign alo = (a_first > a_second) ? a_second : a_first;
  assign ahi = (a_first > a_second) ? a_first  : a_second;
  assign blo = (b_first > b_second) ? b_second : b_first;
  assign bhi = (b_first > b_second) ? b_first  : b_second;

  assign touch   = near_eq(ahi, blo, coord_tol) || near_eq(bhi, alo, coord_tol);
  assign overlap = (ahi > blo) && (alo < bhi);

endmodule

`default_nettype wire

// ===== rtl/segment_intersection_classifier.sv =====
// Top level of the segment intersection classifier: pipeline, registers, classification.
`default_nettype none

// Classifies a pair of segments as disjoint, meeting in a point or overlapping
// along a line. One pair is accepted every cycle while in_ready is high. A pair
// passes in order through an input register, a product stage holding the eight
// cross-product terms and the collinear tests, and a result register for the
// final class, which is formed from the orientation signs and the collinear
// tests. Each stage moves on its own, so a stalled result does not block input
// while earlier stages hold bubbles. The user must write tolerances through the
// configuration port only while no pair is in flight; the block does not enforce it.

module segment_intersection_classifier #(
  parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [sic_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [sic_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]      a_start_x,
  input  wire logic signed [COORD_WIDTH-1:0]      a_start_y,
  input  wire logic signed [COORD_WIDTH-1:0]      a_end_x,
  input  wire logic signed [COORD_WIDTH-1:0]      a_end_y,
  input  wire logic signed [COORD_WIDTH-1:0]      b_start_x,
  input  wire logic signed [COORD_WIDTH-1:0]      b_start_y,
  input  wire logic signed [COORD_WIDTH-1:0]      b_end_x,
  input  wire logic signed [COORD_WIDTH-1:0]      b_end_y,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              contact
);

  import sic_pkg::*;

  localparam int PW = 2 * COORD_WIDTH + 2;

  logic [CROSS_TOL_W-1:0] cross_tol;
  logic [COORD_TOL_W-1:0] coord_tol;

  logic s0_valid;
  logic s1_valid;
  logic s1_ready;
  logic s2_ready;

  logic signed [COORD_WIDTH-1:0] s0_a_start_x;
  logic signed [COORD_WIDTH-1:0] s0_a_start_y;
  logic signed [COORD_WIDTH-1:0] s0_a_end_x;
  logic signed [COORD_WIDTH-1:0] s0_a_end_y;
  logic signed [COORD_WIDTH-1:0] s0_b_start_x;
  logic signed [COORD_WIDTH-1:0] s0_b_start_y;
  logic signed [COORD_WIDTH-1:0] s0_b_end_x;
  logic signed [COORD_WIDTH-1:0] s0_b_end_y;

  logic signed [PW-1:0] prod_uv [4];
  logic signed [PW-1:0] prod_vu [4];
  logic                 touch_next;
  logic                 overlap_next;

  logic signed [PW-1:0] s1_prod_uv [4];
  logic signed [PW-1:0] s1_prod_vu [4];
  logic                 s1_touch;
  logic                 s1_overlap;

  sign_t    sign [4];
  logic     collinear;
  logic     straddle_a;
  logic     straddle_b;
  contact_t contact_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cross_tol <= '0;
      coord_tol <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CROSS_TOL: cross_tol <= cfg_data[CROSS_TOL_W-1:0];
        CFG_COORD_TOL: coord_tol <= cfg_data[COORD_TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = !s0_valid || s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_a_start_x <= a_start_x;
      s0_a_start_y <= a_start_y;
      s0_a_end_x   <= a_end_x;
      s0_a_end_y   <= a_end_y;
      s0_b_start_x <= b_start_x;
      s0_b_start_y <= b_start_y;
      s0_b_end_x   <= b_end_x;
      s0_b_end_y   <= b_end_y;
    end
  end

  sic_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_ab0 (
    .p_x(s0_a_start_x), .p_y(s0_a_start_y),
    .q_x(s0_a_end_x),   .q_y(s0_a_end_y),
    .r_x(s0_b_start_x), .r_y(s0_b_start_y),
    .prod_uv(prod_uv[0]), .prod_vu(prod_vu[0])
  );

  sic_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_ab1 (
    .p_x(s0_a_start_x), .p_y(s0_a_start_y),
    .q_x(s0_a_end_x),   .q_y(s0_a_end_y),
    .r_x(s0_b_end_x),   .r_y(s0_b_end_y),
    .prod_uv(prod_uv[1]), .prod_vu(prod_vu[1])
  );

  sic_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_ba0 (
    .p_x(s0_b_start_x), .p_y(s0_b_start_y),
    .q_x(s0_b_end_x),   .q_y(s0_b_end_y),
    .r_x(s0_a_start_x), .r_y(s0_a_start_y),
    .prod_uv(prod_uv[2]), .prod_vu(prod_vu[2])
  );

  sic_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_ba1 (
    .p_x(s0_b_start_x), .p_y(s0_b_start_y),
    .q_x(s0_b_end_x),   .q_y(s0_b_end_y),
    .r_x(s0_a_end_x),   .r_y(s0_a_end_y),
    .prod_uv(prod_uv[3]), .prod_vu(prod_vu[3])
  );

  sic_collinear #(.COORD_WIDTH(COORD_WIDTH)) u_collinear (
    .a_start_x(s0_a_start_x), .a_start_y(s0_a_start_y),
    .a_end_x(s0_a_end_x),     .a_end_y(s0_a_end_y),
    .b_start_x(s0_b_start_x), .b_start_y(s0_b_start_y),
    .b_end_x(s0_b_end_x),     .b_end_y(s0_b_end_y),
    .coord_tol(coord_tol),
    .touch(touch_next),
    .overlap(overlap_next)
  );

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_valid && s1_ready) begin
      s1_prod_uv <= prod_uv;
      s1_prod_vu <= prod_vu;
      s1_touch   <= touch_next;
      s1_overlap <= overlap_next;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_sign
    sic_sign #(.COORD_WIDTH(COORD_WIDTH)) u_sign (
      .prod_uv(s1_prod_uv[i]),
      .prod_vu(s1_prod_vu[i]),
      .cross_tol(cross_tol),
      .sign(sign[i])
    );
  end

  assign collinear  = sign[0].zero && sign[1].zero && sign[2].zero && sign[3].zero;
  assign straddle_a = sign[0].zero || sign[1].zero || (sign[0].neg != sign[1].neg);
  assign straddle_b = sign[2].zero || sign[3].zero || (sign[2].neg != sign[3].neg);

  always_comb begin
    if (collinear) begin
      if (s1_touch) begin
        contact_next = CONTACT_POINT;
      end else if (s1_overlap) begin
        contact_next = CONTACT_LINE;
      end else begin
        contact_next = CONTACT_NONE;
      end
    end else if (straddle_a && straddle_b) begin
      contact_next = CONTACT_POINT;
    end else begin
      contact_next = CONTACT_NONE;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      contact <= contact_next;
    end
  end

  a_contact_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (contact == CONTACT_NONE || contact == CONTACT_POINT ||
                   contact == CONTACT_LINE))
    else $error("contact holds an unused code");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output side takes beats");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted beat did not reach the output in three cycles");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!out_valid && !s1_valid && !s0_valid))
    else $error("pipeline valid bits not cleared by reset");

endmodule

`default_nettype wire

// ===== tb/sv/segment_intersection_classifier_tb.sv =====
// Self-checking testbench for the segment intersection classifier.
module segment_intersection_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sic_pkg::*;

  localparam int COORD_W        = COORD_WIDTH_DEF;
  localparam int COORD_MIN      = -(1 << (COORD_W - 1));
  localparam int COORD_MAX      = (1 << (COORD_W - 1)) - 1;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_PAIRS    = 240;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t ax0, ay0, ax1, ay1;
    coord_t bx0, by0, bx1, by1;
  } seg_pair_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  coord_t                 a_start_x = '0;
  coord_t                 a_start_y = '0;
  coord_t                 a_end_x = '0;
  coord_t                 a_end_y = '0;
  coord_t                 b_start_x = '0;
  coord_t                 b_start_y = '0;
  coord_t                 b_end_x = '0;
  coord_t                 b_end_y = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             contact;

  logic [CROSS_TOL_W-1:0] cross_tol = '0;
  logic [COORD_TOL_W-1:0] coord_tol = '0;

  contact_t expected_contacts[$];
  contact_t head_contact;
  bit       steady = 1'b0;
  int       stall_left = 0;
  int       idle_cycles = 0;
  int       errors = 0;
  int       pairs_sent = 0;
  int       settings_used = 1;
  int       class_seen[3] = '{0, 0, 0};

  segment_intersection_classifier #(
    .COORD_WIDTH(COORD_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .a_start_x(a_start_x),
    .a_start_y(a_start_y),
    .a_end_x  (a_end_x),
    .a_end_y  (a_end_y),
    .b_start_x(b_start_x),
    .b_start_y(b_start_y),
    .b_end_x  (b_end_x),
    .b_end_y  (b_end_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .contact  (contact)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int srange(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return srange(1, 3);
    return srange(8, 30);
  endfunction

  function automatic int orientation(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
    longint c, mag;
    c = (qx - px) * (ry - py) - (rx - px) * (qy - py);
    mag = (c < 0) ? -c : c;
    if (mag <= longint'(cross_tol)) return 0;
    return (c < 0) ? -1 : 1;
  endfunction

  function automatic bit within_tol(longint a, longint b);
    longint d;
    d = a - b;
    return ((d < 0) ? -d : d) <= longint'(coord_tol);
  endfunction

  function automatic contact_t classify_contact(seg_pair_t p);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint alo, ahi, blo, bhi, t;
    int     s1, s2, s3, s4;
    bit     use_y;
    ax0 = p.ax0; ay0 = p.ay0; ax1 = p.ax1; ay1 = p.ay1;
    bx0 = p.bx0; by0 = p.by0; bx1 = p.bx1; by1 = p.by1;
    s1 = orientation(ax0, ay0, ax1, ay1, bx0, by0);
    s2 = orientation(ax0, ay0, ax1, ay1, bx1, by1);
    s3 = orientation(bx0, by0, bx1, by1, ax0, ay0);
    s4 = orientation(bx0, by0, bx1, by1, ax1, ay1);
    if (s1 == 0 && s2 == 0 && s3 == 0 && s4 == 0) begin
      use_y = within_tol(ax0, ax1) && within_tol(bx0, bx1);
      alo = use_y ? ay0 : ax0;
      ahi = use_y ? ay1 : ax1;
      blo = use_y ? by0 : bx0;
      bhi = use_y ? by1 : bx1;
      if (alo > ahi) begin
        t = alo; alo = ahi; ahi = t;
      end
      if (blo > bhi) begin
        t = blo; blo = bhi; bhi = t;
      end
      if (within_tol(ahi, blo) || within_tol(bhi, alo)) return CONTACT_POINT;
      if (ahi > blo && alo < bhi) return CONTACT_LINE;
      return CONTACT_NONE;
    end
    if (s1 * s2 <= 0 && s3 * s4 <= 0) return CONTACT_POINT;
    return CONTACT_NONE;
  endfunction

  function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.ax0 = ax0[COORD_W-1:0]; p.ay0 = ay0[COORD_W-1:0];
    p.ax1 = ax1[COORD_W-1:0]; p.ay1 = ay1[COORD_W-1:0];
    p.bx0 = bx0[COORD_W-1:0]; p.by0 = by0[COORD_W-1:0];
    p.bx1 = bx1[COORD_W-1:0]; p.by1 = by1[COORD_W-1:0];
    return p;
  endfunction

  function automatic seg_pair_t random_pair();
    int c[8];
    int kind, px, py, dx, dy, tk, k, pick;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      for (k = 0; k < 8; k++) c[k] = $urandom();
    end else if (kind < 30) begin
      for (k = 0; k < 8; k++) c[k] = srange(-64, 64);
    end else if (kind < 50 || (kind >= 75 && kind < 90)) begin
      px = srange(-3000, 3000);
      py = srange(-3000, 3000);
      dx = srange(-40, 40);
      dy = srange(-40, 40);
      if ($urandom_range(0, 4) == 0) dy = 0;
      for (k = 0; k < 4; k++) begin
        tk = srange(-10, 10);
        c[2*k]   = px + tk * dx;
        c[2*k+1] = py + tk * dy;
      end
      if (kind >= 75) begin
        pick = srange(0, 7);
        c[pick] = c[pick] + srange(-4, 4);
      end
    end else if (kind < 60) begin
      px = srange(-3000, 3000);
      for (k = 0; k < 4; k++) begin
        c[2*k]   = px + (($urandom_range(0, 3) == 0) ? srange(-3, 3) : 0);
        c[2*k+1] = srange(-300, 300);
      end
    end else if (kind < 75) begin
      for (k = 0; k < 8; k++) c[k] = srange(-200, 200);
      pick = srange(0, 3);
      c[4 + 2*(pick & 1)] = c[2*(pick >> 1)];
      c[5 + 2*(pick & 1)] = c[2*(pick >> 1) + 1];
    end else begin
      for (k = 0; k < 8; k++) begin
        case ($urandom_range(0, 4))
          0:       c[k] = COORD_MIN;
          1:       c[k] = COORD_MAX;
          2:       c[k] = 0;
          3:       c[k] = -1;
          default: c[k] = $urandom();
        endcase
      end
    end
    return make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endfunction

  task automatic send_pair(input seg_pair_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    a_start_x <= p.ax0;
    a_start_y <= p.ay0;
    a_end_x   <= p.ax1;
    a_end_y   <= p.ay1;
    b_start_x <= p.bx0;
    b_start_y <= p.by0;
    b_end_x   <= p.bx1;
    b_end_y   <= p.by1;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_contacts.push_back(classify_contact(p));
    pairs_sent++;
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerances(input logic [CFG_DATA_W-1:0] cross_data,
                                  input logic [CFG_DATA_W-1:0] coord_data);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CROSS_TOL;
    cfg_data  <= cross_data;
    @(posedge clk);
    cfg_index <= CFG_COORD_TOL;
    cfg_data  <= coord_data;
    @(posedge clk);
    // spare indexes must leave both tolerances alone
    cfg_index <= CFG_SPARE_LO;
    cfg_data  <= $urandom();
    @(posedge clk);
    cfg_index <= CFG_SPARE_HI;
    cfg_data  <= $urandom();
    @(posedge clk);
    cfg_we    <= 1'b0;
    cross_tol = cross_data[CROSS_TOL_W-1:0];
    coord_tol = coord_data[COORD_TOL_W-1:0];
    settings_used++;
  endtask

  task automatic test_directed_geometry();
    send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0));
    send_pair(make_pair(0, 0, 160, 0, 0, 16, 160, 16));
    send_pair(make_pair(0, 0, 160, 0, 80, 0, 80, 160));
    send_pair(make_pair(0, 0, 160, 0, 200, 0, 200, 160));
    send_pair(make_pair(0, 0, 100, 0, 50, 0, 150, 0));
    send_pair(make_pair(100, 0, 0, 0, 150, 0, 100, 0));
    send_pair(make_pair(0, 0, 50, 0, 60, 0, 100, 0));
    send_pair(make_pair(5, 0, 5, 100, 5, 200, 5, 50));
    send_pair(make_pair(48, 48, 48, 48, 0, 0, 96, 96));
    send_pair(make_pair(7, 7, 7, 7, 7, 7, 7, 7));
    send_pair(make_pair(7, 7, 7, 7, 20, -3, 20, -3));
    send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                        COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                        COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_pair(make_pair(COORD_MIN, 0, 0, 0, 0, 0, COORD_MAX, 0));
    send_pair(make_pair(0, 0, 100, 50, 100, 50, 200, -30));
  endtask

  task automatic test_tolerance_edges();
    int k;
    for (k = 0; k < 3; k++) begin
      case (k)
        0:       write_tolerances(32'd16, 32'd3);
        1:       write_tolerances(32'd15, 32'hA5A5_5A02);
        default: write_tolerances(32'hFFFF_FFFF, 32'h0000_00FF);
      endcase
      send_pair(make_pair(0, 0, 16, 0, 0, 1, 16, 1));
      send_pair(make_pair(0, 0, 100, 0, 103, 0, 200, 0));
      send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                          COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
      send_pair(make_pair(0, 0, 2, 160, 3, 200, 1, 40));
    end
  endtask

  task automatic test_random_streams();
    int phase, i;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       write_tolerances(32'd0, 32'd0);
        1:       write_tolerances($urandom_range(1, 255), $urandom_range(1, 15));
        2:       write_tolerances($urandom(), $urandom());
        3:       write_tolerances(32'hFFFF_FFFF, 32'h0000_00FF);
        4:       write_tolerances(32'd0, 32'h0000_00FF);
        default: write_tolerances($urandom_range(1, 4000), 32'd0);
      endcase
      for (i = 0; i < PHASE_PAIRS; i++) begin
        if (i % 60 == 0) steady = ($urandom_range(0, 2) == 0);
        send_pair(random_pair());
      end
      steady = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_contacts.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, got %0d", $time, contact);
      end else begin
        head_contact = expected_contacts.pop_front();
        class_seen[head_contact]++;
        if (contact !== head_contact) begin
          errors++;
          $display("%0t: contact mismatch, expected %s (%0d), actual %0d",
                   $time, head_contact.name(), head_contact, contact);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (steady || $urandom_range(0, 99) < 70) begin
      out_ready <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 9) == 0) ? srange(10, 40) : srange(0, 2);
      out_ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, expected_contacts.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed_geometry();
    test_tolerance_edges();
    test_random_streams();
    settle_idle();
    $display("Classified %0d segment pairs under %0d tolerance settings:", pairs_sent,
             settings_used);
    $display("  %0d disjoint, %0d point contacts, %0d collinear overlaps, %0d errors",
             class_seen[CONTACT_NONE], class_seen[CONTACT_POINT], class_seen[CONTACT_LINE],
             errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
